// File: rtl/mvrt_pkg.sv
// Shared types and constants for the multichannel virtual rate timer.
package mvrt_pkg;

   localparam logic [1:0] CMD_TICK     = 2'd0;
   localparam logic [1:0] CMD_SET_RATE = 2'd1;
   localparam logic [1:0] CMD_ARM      = 2'd2;
   localparam logic [1:0] CMD_POLL     = 2'd3;

   localparam logic [7:0]         WRITE_LEN   = 8'd4;
   localparam logic signed [31:0] MIN_RATE_HZ = 32'sd2;

   // Number of log2 rate codes, and so of period residue counters.
   localparam int RATE_CODES = 16;
   localparam int MASK_W     = 8;

   typedef struct packed {
      logic [1:0]         command;
      logic [2:0]         channel;
      logic signed [31:0] rate_hz;
      logic [7:0]         byte_count;
   } req_type;

   typedef struct packed {
      logic              status;
      logic              strike_flag;
      logic [MASK_W-1:0] strike_mask;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_WALK,
      ST_RESP
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       capture;
      logic       decode;
      logic       walk;
      logic       advance;
      logic       respond;
      logic [2:0] walk_idx;
   } ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_tick;
   } sts_type;

endpackage

// File: rtl/mvrt_ctrl.sv
// Controller state machine: sequences decode, the channel walk and the response.
module mvrt_ctrl
   import mvrt_pkg::*;
#(
   parameter int CHANNELS = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  sts_type sts,
   output ctl_type ctl
);

   localparam int         NCH  = (CHANNELS < 8) ? CHANNELS : 8;
   localparam logic [2:0] LAST = 3'(NCH - 1);

   state_type  state_ff, state_in;
   logic [2:0] walk_ff, walk_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         walk_ff  <= 3'd0;
      end else begin
         state_ff <= state_in;
         walk_ff  <= walk_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            state_in = sts.is_tick ? ST_WALK : ST_RESP;
         end
         ST_WALK: begin
            if (walk_ff == LAST) state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      walk_in = walk_ff;
      if (state_ff == ST_DECODE) walk_in = 3'd0;
      else if (state_ff == ST_WALK) walk_in = walk_ff + 3'd1;
   end

   always_comb begin
      ctl          = '0;
      ctl.walk_idx = walk_ff;
      busy         = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy        = 1'b0;
            ctl.capture = start;
         end
         ST_DECODE: begin
            ctl.decode = 1'b1;
         end
         ST_WALK: begin
            ctl.walk    = 1'b1;
            ctl.advance = (walk_ff == LAST);
         end
         ST_RESP: begin
            ctl.respond = 1'b1;
         end
         default: busy = 1'b1;
      endcase
   end

endmodule

// File: rtl/mvrt_datapath.sv
// Datapath: request register, channel state, tick counter and period residues.
module mvrt_datapath
   import mvrt_pkg::*;
#(
   parameter int CHANNELS    = 8,
   parameter int BASE_HZ     = 8192,
   parameter int MAX_RATE_HZ = 1024,
   parameter int TICK_SCALE  = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  ctl_type ctl,
   output sts_type sts,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int NCH = (CHANNELS < 8) ? CHANNELS : 8;
   localparam int RW  = $clog2(BASE_HZ + 1);

   req_type           req_ff;
   logic              status_ff, status_in;
   logic [MASK_W-1:0] flags_ff, flags_in;
   logic [3:0]        rate_lg_ff [MASK_W];
   logic [3:0]        rate_lg_in [MASK_W];
   logic [31:0]       tick_count_ff, tick_count_in;
   logic              strobe_ff;
   rsp_type           rsp_ff, rsp_in;

   logic [RATE_CODES-1:0] res_zero;
   logic                  wrap;
   logic                  valid_ch;
   logic                  bad_rate;
   logic [31:0]           rate_u;
   logic [3:0]            new_lg;
   logic                  hit;

   assign sts.is_tick = (req_ff.command == CMD_TICK);
   assign valid_ch    = (int'(req_ff.channel) < NCH);
   assign rate_u      = req_ff.rate_hz;
   assign wrap        = (tick_count_ff == '1);

   always_comb begin
      bad_rate = (req_ff.byte_count != WRITE_LEN)
               || (req_ff.rate_hz < MIN_RATE_HZ)
               || (req_ff.rate_hz > signed'(32'(MAX_RATE_HZ)))
               || ((rate_u & (rate_u - 32'd1)) != 32'd0);
   end

   // The rate is a power of two by the time it is stored, so any set bit gives its log2.
   always_comb begin
      new_lg = 4'd0;
      for (int j = 0; j < RATE_CODES; j++) begin
         if (rate_u[j]) new_lg = 4'(j);
      end
   end

   assign hit = res_zero[rate_lg_ff[ctl.walk_idx]];

   always_comb begin
      status_in  = status_ff;
      flags_in   = flags_ff;
      rate_lg_in = rate_lg_ff;
      if (ctl.decode) begin
         status_in = 1'b0;
         if (req_ff.command != CMD_TICK) begin
            if (!valid_ch) begin
               status_in = 1'b1;
            end else begin
               case (req_ff.command)
                  CMD_SET_RATE: begin
                     if (bad_rate) status_in = 1'b1;
                     else rate_lg_in[req_ff.channel] = new_lg;
                  end
                  CMD_ARM: flags_in[req_ff.channel] = 1'b0;
                  default: status_in = 1'b0;
               endcase
            end
         end
      end
      if (ctl.walk && hit) flags_in[ctl.walk_idx] = 1'b1;
   end

   assign tick_count_in = ctl.advance ? tick_count_ff + 32'd1 : tick_count_ff;

   // One residue counter per rate code tracks the tick count modulo that code's period.
   for (genvar g = 0; g < RATE_CODES; g++) begin : g_res
      localparam int RAW    = (BASE_HZ >> g) / TICK_SCALE;
      localparam int PERIOD = (RAW == 0) ? 1 : RAW;
      localparam logic [RW-1:0] LAST_RES = RW'(PERIOD - 1);

      logic [RW-1:0] res_ff, res_in;

      always_comb begin
         res_in = res_ff;
         if (ctl.advance) begin
            if (wrap || res_ff == LAST_RES) res_in = '0;
            else res_in = res_ff + RW'(1);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            res_ff <= '0;
         end else begin
            res_ff <= res_in;
         end
      end

      assign res_zero[g] = (res_ff == '0);
   end

   always_comb begin
      rsp_in.status      = status_ff;
      rsp_in.strike_flag = valid_ch && !status_ff && flags_ff[req_ff.channel];
      rsp_in.strike_mask = flags_ff;
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) req_ff <= req_data;
      if (ctl.respond) rsp_ff <= rsp_in;
      status_ff <= status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff      <= '0;
         tick_count_ff <= '0;
         strobe_ff     <= 1'b0;
         for (int i = 0; i < MASK_W; i++) rate_lg_ff[i] <= 4'd1;
      end else begin
         flags_ff      <= flags_in;
         tick_count_ff <= tick_count_in;
         strobe_ff     <= ctl.respond;
         rate_lg_ff    <= rate_lg_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// File: rtl/multichannel_virtual_rate_timer.sv
// Top level of the multichannel virtual rate timer.
// A tick beat goes through decode, then a walk over the min(CHANNELS, 8) channels that
// checks each channel's period residue in turn, then the response.
// Set rate, arm and poll beats go from decode straight to the response. The result
// strobe rises in the cycle after the response state, the same cycle in which busy
// falls and a new beat may start. Synchronous reset clears the tick count and flags,
// sets every channel to 2 Hz and leaves the block idle.
module multichannel_virtual_rate_timer
   import mvrt_pkg::*;
#(
   parameter int CHANNELS    = 8,
   parameter int BASE_HZ     = 8192,
   parameter int MAX_RATE_HZ = 1024,
   parameter int TICK_SCALE  = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   ctl_type ctl;
   sts_type sts;

   mvrt_ctrl #(
      .CHANNELS (CHANNELS)
   ) u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .ctl   (ctl)
   );

   mvrt_datapath #(
      .CHANNELS    (CHANNELS),
      .BASE_HZ     (BASE_HZ),
      .MAX_RATE_HZ (MAX_RATE_HZ),
      .TICK_SCALE  (TICK_SCALE)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .ctl        (ctl),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

// File: rtl/mvrt_checker.sv
// Port-level checker for the multichannel virtual rate timer, bound to the top level.
module mvrt_checker
   import mvrt_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   // An accepted beat keeps the block busy in the following cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted beat did not make the block busy");

   // Each result appears exactly when the block returns to idle.
   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("busy fell without a result");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   // A rejected beat never reports a set flag.
   a_reject_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status |-> !rsp_data.strike_flag)
      else $error("rejected beat reported a strike flag");

endmodule

bind multichannel_virtual_rate_timer mvrt_checker u_mvrt_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

// File: verif/testbench.sv
// Self-checking testbench for the multichannel virtual rate timer.
`timescale 1ns / 1ps

module testbench
   import mvrt_pkg::*;
();

   localparam int CHANNELS       = 8;
   localparam int BASE_HZ        = 8192;
   localparam int MAX_RATE_HZ    = 1024;
   localparam int TICK_SCALE     = 16;
   localparam int RANDOM_BEATS   = 1230;
   localparam int WATCHDOG_LIMIT = 500;
   localparam int DRAIN_CYCLES   = 20;

   typedef struct {
      req_type req;
      bit      has_literal;
      rsp_type literal;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // Timer state as the block should hold it.
   logic [31:0]         tick_count;
   logic [3:0]          rate_code [CHANNELS];
   logic [CHANNELS-1:0] strike_flags;

   rsp_type      pending_results[$];
   stim_row_type directed_rows[$];
   int           mismatch_count = 0;
   int           idle_cycles = 0;
   int           burst_left = 0;

   always #5 clock = ~clock;

   multichannel_virtual_rate_timer #(
      .CHANNELS    (CHANNELS),
      .BASE_HZ     (BASE_HZ),
      .MAX_RATE_HZ (MAX_RATE_HZ),
      .TICK_SCALE  (TICK_SCALE)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   function automatic void reset_timer_state();
      tick_count   = '0;
      strike_flags = '0;
      for (int i = 0; i < CHANNELS; i++) rate_code[i] = 4'd1;
   endfunction

   // Applies one beat to the timer state and returns the result it should give.
   function automatic rsp_type next_timer_result(input req_type r);
      rsp_type            res;
      logic [31:0]        period;
      logic signed [31:0] rate;
      logic [31:0]        rate_u;
      logic [3:0]         lg;
      res  = '0;
      rate = r.rate_hz;
      case (r.command)
         CMD_TICK: begin
            for (int i = 0; i < CHANNELS; i++) begin
               period = (32'(BASE_HZ) >> rate_code[i]) / 32'(TICK_SCALE);
               if (period == 0) period = 1;
               if (tick_count % period == 0) strike_flags[i] = 1'b1;
            end
            tick_count = tick_count + 1;
         end
         CMD_SET_RATE: begin
            if (r.byte_count != WRITE_LEN || rate < MIN_RATE_HZ || rate > MAX_RATE_HZ ||
                (rate & (rate - 1)) != 0) begin
               res.status = 1'b1;
            end else begin
               rate_u = rate;
               lg = '0;
               while (rate_u > 1) begin
                  rate_u = rate_u >> 1;
                  lg++;
               end
               rate_code[r.channel] = lg;
            end
         end
         CMD_ARM: strike_flags[r.channel] = 1'b0;
         default: ;
      endcase
      res.strike_flag = res.status ? 1'b0 : strike_flags[r.channel];
      res.strike_mask = strike_flags;
      return res;
   endfunction

   function automatic req_type random_request();
      req_type r;
      int      kind;
      kind         = $urandom_range(0, 99);
      r.channel    = 3'($urandom_range(0, CHANNELS - 1));
      r.rate_hz    = $urandom;
      r.byte_count = 8'($urandom_range(0, 255));
      if (kind < 40) begin
         r.command = CMD_TICK;
      end else if (kind < 65) begin
         r.command = CMD_SET_RATE;
         case ($urandom_range(0, 5))
            0: ;
            1: begin
               r.byte_count = WRITE_LEN;
               r.rate_hz    = $urandom_range(0, 2 * MAX_RATE_HZ);
            end
            2: r.rate_hz = 32'sd1 << $urandom_range(1, 10);
            default: begin
               r.byte_count = WRITE_LEN;
               r.rate_hz    = 32'sd1 << $urandom_range(1, 10);
            end
         endcase
      end else if (kind < 80) begin
         r.command = CMD_ARM;
      end else begin
         r.command = CMD_POLL;
      end
      return r;
   endfunction

   task automatic add_row(input logic [1:0] cmd, input logic [2:0] ch,
                          input logic signed [31:0] rate, input logic [7:0] len,
                          input bit has_literal, input logic status = 1'b0,
                          input logic flag = 1'b0, input logic [7:0] mask = 8'h00);
      stim_row_type row;
      row.req         = '{command: cmd, channel: ch, rate_hz: rate, byte_count: len};
      row.has_literal = has_literal;
      row.literal     = '{status: status, strike_flag: flag, strike_mask: mask};
      directed_rows.push_back(row);
   endtask

   // Holds the beat on the request port until the block takes it.
   task automatic send_beat(input req_type r, input bit has_literal, input rsp_type literal);
      rsp_type predicted;
      if (burst_left == 0) begin
         int gap;
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 16);
      end
      burst_left--;
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      predicted = next_timer_result(r);
      pending_results.push_back(has_literal ? literal : predicted);
   endtask

   initial begin
      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      reset_timer_state();

      add_row(CMD_POLL,     3'd0, 32'sd0,         8'd4,   1, 1'b0, 1'b0, 8'h00);
      add_row(CMD_TICK,     3'd3, 32'sd0,         8'd0,   1, 1'b0, 1'b1, 8'hff);
      add_row(CMD_ARM,      3'd3, 32'sd0,         8'd4,   1, 1'b0, 1'b0, 8'hf7);
      add_row(CMD_SET_RATE, 3'd1, 32'sh7fffffff,  8'd4,   1, 1'b1, 1'b0, 8'hf7);
      add_row(CMD_SET_RATE, 3'd1, 32'sh80000000,  8'd4,   1, 1'b1, 1'b0, 8'hf7);
      add_row(CMD_SET_RATE, 3'd1, 32'sd1,         8'd4,   1, 1'b1, 1'b0, 8'hf7);
      add_row(CMD_SET_RATE, 3'd1, 32'sd0,         8'd4,   1, 1'b1, 1'b0, 8'hf7);
      add_row(CMD_SET_RATE, 3'd1, 32'sd2048,      8'd4,   1, 1'b1, 1'b0, 8'hf7);
      add_row(CMD_SET_RATE, 3'd1, 32'sd1025,      8'd4,   1, 1'b1, 1'b0, 8'hf7);
      add_row(CMD_SET_RATE, 3'd1, 32'sd12,        8'd4,   1, 1'b1, 1'b0, 8'hf7);
      add_row(CMD_SET_RATE, 3'd1, 32'sd1024,      8'd0,   1, 1'b1, 1'b0, 8'hf7);
      add_row(CMD_SET_RATE, 3'd1, 32'sd1024,      8'd255, 1, 1'b1, 1'b0, 8'hf7);
      add_row(CMD_SET_RATE, 3'd1, 32'sd1024,      8'd3,   1, 1'b1, 1'b0, 8'hf7);
      add_row(CMD_SET_RATE, 3'd1, 32'sd1024,      8'd5,   1, 1'b1, 1'b0, 8'hf7);
      add_row(CMD_SET_RATE, 3'd0, 32'sd1024,      8'd4,   1, 1'b0, 1'b1, 8'hf7);
      add_row(CMD_SET_RATE, 3'd7, 32'sd2,         8'd4,   1, 1'b0, 1'b1, 8'hf7);
      add_row(CMD_SET_RATE, 3'd2, 32'sd512,       8'd4,   0);
      add_row(CMD_ARM,      3'd0, 32'sh80000000,  8'd255, 1, 1'b0, 1'b0, 8'hf6);
      add_row(CMD_TICK,     3'd0, 32'sh7fffffff,  8'd255, 0);
      add_row(CMD_ARM,      3'd2, 32'sd0,         8'd0,   0);
      add_row(CMD_TICK,     3'd2, 32'sd0,         8'd0,   0);
      add_row(CMD_POLL,     3'd7, 32'sd0,         8'd0,   0);
      add_row(CMD_SET_RATE, 3'd4, 32'sd64,        8'd4,   0);
      add_row(CMD_TICK,     3'd4, 32'sd0,         8'd0,   0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_beat(directed_rows[i].req, directed_rows[i].has_literal, directed_rows[i].literal);
      for (int n = 0; n < RANDOM_BEATS; n++) send_beat(random_request(), 0, '0);
      start <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Result checking and the watchdog, both on values sampled at the clock edge.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: status %0d flag %0d mask %02h",
                        rsp_data.status, rsp_data.strike_flag, rsp_data.strike_mask);
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.status !== want.status || rsp_data.strike_flag !== want.strike_flag ||
                rsp_data.strike_mask !== want.strike_mask) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected status %0d flag %0d mask %02h, got %0d %0d %02h",
                           want.status, want.strike_flag, want.strike_mask,
                           rsp_data.status, rsp_data.strike_flag, rsp_data.strike_mask);
            end
         end
      end
      if (reset || rsp_strobe || (start && !busy)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

endmodule
